// ----- rtl/core/uepb_pkg.sv -----
// Shared types and constants for the ultrasonic echo proximity beeper.
// Used by every module under rtl/core; depends on nothing.
package uepb_pkg;

   localparam int TS_W        = 16;
   localparam int CFG_W       = 16;
   localparam int WIDTH_W     = 16;
   localparam int DIST_W      = 14;
   localparam int PERIOD_W    = 16;
   localparam int DIV_NUM_W   = 20;
   localparam int DIV_DEN_W   = 15;
   localparam int DIV_STEPS   = DIV_NUM_W;
   localparam int PROD_W      = CFG_W + DIV_DEN_W;
   localparam int DIST_PROD_W = 40;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 56;

   localparam logic [1:0] OP_ECHO   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [2:0] K_NONE   = 3'd0;
   localparam logic [2:0] K_RISE   = 3'd1;
   localparam logic [2:0] K_FALL   = 3'd2;
   localparam logic [2:0] K_TICK   = 3'd3;
   localparam logic [2:0] K_UPDATE = 3'd4;

   localparam logic [1:0] ZONE_BEEP  = 2'd0;
   localparam logic [1:0] ZONE_SOLID = 2'd1;
   localparam logic [1:0] ZONE_OFF   = 2'd2;

   localparam logic [1:0] CSR_NO_OBSTACLE = 2'd0;
   localparam logic [1:0] CSR_NEAR        = 2'd1;
   localparam logic [1:0] CSR_FAR         = 2'd2;

   localparam logic [CFG_W-1:0] NO_OBSTACLE_RESET = 16'd33;
   localparam logic [CFG_W-1:0] NEAR_RESET        = 16'd40;
   localparam logic [CFG_W-1:0] FAR_RESET         = 16'd800;

   localparam logic [DIV_NUM_W-1:0] PERIOD_NUM    = 20'd580000;
   localparam logic [DIV_NUM_W-1:0] PERIOD_NUM_M1 = 20'd579999;
   localparam logic [17:0]          DEN_BASE      = 18'd17980;
   localparam logic [PERIOD_W-1:0]  PERIOD_MAX    = 16'hFFFF;

   // distance = (width * 10 + 29) / 58 as (width * 10m + 29m) >> 26, m = ceil(2^26 / 58)
   localparam logic [23:0]            DIST_RECIP10 = 24'd11570500;
   localparam logic [DIST_PROD_W-1:0] DIST_BIAS    = 40'd33554450;

   typedef struct packed {
      logic [2:0]      kind;
      logic [TS_W-1:0] ts;
   } item_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_ms;
      logic [DIST_W-1:0]   distance_tenths_cm;
      logic [WIDTH_W-1:0]  echo_width_us;
      logic [1:0]          zone;
      logic                beep_active;
      logic                beeper_on;
   } rsp_type;

endpackage

// ----- rtl/core/uepb_front.sv -----
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on uepb_pkg.
module uepb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [1:0]                            req_tuser,
   input  logic [uepb_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                  q_valid,
   output uepb_pkg::item_type                    q_item,
   input  logic                                  q_pop
);

   uepb_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   uepb_pkg::item_type cls;
   logic               push;

   always_comb begin
      cls.ts = req_tdata[uepb_pkg::TS_W:1];
      case (req_tuser)
         uepb_pkg::OP_ECHO: begin
            cls.kind = req_tdata[0] ? uepb_pkg::K_RISE : uepb_pkg::K_FALL;
         end
         uepb_pkg::OP_TICK: begin
            cls.kind = uepb_pkg::K_TICK;
         end
         uepb_pkg::OP_UPDATE: begin
            cls.kind = uepb_pkg::K_UPDATE;
         end
         default: begin
            cls.kind = uepb_pkg::K_NONE;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/core/uepb_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on uepb_pkg.
module uepb_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [uepb_pkg::DIV_NUM_W-1:0]     num,
   input  logic [uepb_pkg::DIV_DEN_W-1:0]     den,
   output logic                               done,
   output logic [uepb_pkg::DIV_NUM_W-1:0]     quot
);

   localparam int NW = uepb_pkg::DIV_NUM_W;
   localparam int DW = uepb_pkg::DIV_DEN_W;
   localparam int CW = $clog2(uepb_pkg::DIV_STEPS + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW+1:0] diff;

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = CW'(uepb_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         if (!diff[DW+1]) begin
            rem_in = diff[DW-1:0];
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ----- rtl/core/uepb_back.sv -----
// Back end: holds the sensor state and settings, executes queued requests and
// registers the response. Depends on uepb_pkg; drives the uepb_div unit.
module uepb_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [uepb_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                               q_valid,
   input  uepb_pkg::item_type                 q_item,
   output logic                               q_pop,
   output logic                               div_start,
   output logic [uepb_pkg::DIV_NUM_W-1:0]     div_num,
   output logic [uepb_pkg::DIV_DEN_W-1:0]     div_den,
   input  logic                               div_done,
   input  logic [uepb_pkg::DIV_NUM_W-1:0]     div_quot,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output uepb_pkg::rsp_type                  rsp
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAIT = 1'b1;

   localparam int CW = uepb_pkg::CFG_W;
   localparam int DW = uepb_pkg::DIV_DEN_W;
   localparam int NW = uepb_pkg::DIV_NUM_W;
   localparam int PW = uepb_pkg::PROD_W;
   localparam int XW = uepb_pkg::DIST_PROD_W;

   logic [CW-1:0] no_obs_ff, near_ff, far_ff;

   logic                          state_ff, state_in;
   logic [2:0]                    job_ff, job_in;
   logic                          seen_ff, seen_in;
   logic [uepb_pkg::TS_W-1:0]     start_ff, start_in;
   logic [uepb_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [uepb_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic [15:0]                   tick_ff, tick_in;
   logic [uepb_pkg::PERIOD_W-1:0] half_ff, half_in;
   logic                          toggle_ff, toggle_in;
   logic                          beeper_ff, beeper_in;
   logic [1:0]                    zone_ff, zone_in;
   logic [DW-1:0]                 den_ff, den_in;
   logic [1:0]                    mstep_ff, mstep_in;
   logic [PW-1:0]                 prod_ff, prod_in;
   logic                          gt_ff, gt_in, le_ff, le_in, ge_ff, ge_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   uepb_pkg::rsp_type             rsp_ff, rsp_in;

   logic [uepb_pkg::WIDTH_W-1:0] fall_width;
   logic [17:0]                  three_w;
   logic                         den_pos;
   logic [DW-1:0]                den_val;
   logic [15:0]                  tick_next;
   logic [CW-1:0]                mul_a;
   logic [PW-1:0]                num_ext;
   logic [XW-1:0]                dist_prod;
   logic                         emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_obs_ff <= uepb_pkg::NO_OBSTACLE_RESET;
         near_ff   <= uepb_pkg::NEAR_RESET;
         far_ff    <= uepb_pkg::FAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            uepb_pkg::CSR_NO_OBSTACLE: no_obs_ff <= csr_wdata;
            uepb_pkg::CSR_NEAR:        near_ff   <= csr_wdata;
            uepb_pkg::CSR_FAR:         far_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fall_width = q_item.ts - start_ff;
      three_w    = {2'b00, width_ff} + {1'b0, width_ff, 1'b0};
      den_pos    = three_w < uepb_pkg::DEN_BASE;
      den_val    = DW'(uepb_pkg::DEN_BASE - three_w);
      tick_next  = tick_ff + 16'd1;
      num_ext    = PW'(uepb_pkg::PERIOD_NUM);
      dist_prod  = XW'(width_ff) * XW'(uepb_pkg::DIST_RECIP10) + uepb_pkg::DIST_BIAS;
      case (mstep_ff)
         2'd0:    mul_a = no_obs_ff;
         2'd1:    mul_a = near_ff;
         default: mul_a = far_ff;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      seen_in   = seen_ff;
      start_in  = start_ff;
      width_in  = width_ff;
      dist_in   = dist_ff;
      tick_in   = tick_ff;
      half_in   = half_ff;
      toggle_in = toggle_ff;
      beeper_in = beeper_ff;
      zone_in   = zone_ff;
      den_in    = den_ff;
      mstep_in  = mstep_ff;
      prod_in   = prod_ff;
      gt_in     = gt_ff;
      le_in     = le_ff;
      ge_in     = ge_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      emit      = 1'b0;
      q_pop     = (state_ff == ST_IDLE) && q_valid && (!rsp_valid_ff || rsp_tready);

      if (q_pop) begin
         case (q_item.kind)
            uepb_pkg::K_RISE: begin
               if (!seen_ff) begin
                  seen_in  = 1'b1;
                  start_in = q_item.ts;
               end
               emit = 1'b1;
            end
            uepb_pkg::K_FALL: begin
               if (seen_ff) begin
                  seen_in  = 1'b0;
                  width_in = fall_width;
                  job_in   = uepb_pkg::K_FALL;
                  state_in = ST_WAIT;
               end else begin
                  emit = 1'b1;
               end
            end
            uepb_pkg::K_TICK: begin
               if (toggle_ff && (half_ff <= tick_next)) begin
                  beeper_in = ~beeper_ff;
                  tick_in   = '0;
               end else begin
                  tick_in = tick_next;
               end
               emit = 1'b1;
            end
            uepb_pkg::K_UPDATE: begin
               if (!den_pos) begin
                  half_in   = uepb_pkg::PERIOD_MAX;
                  toggle_in = 1'b0;
                  beeper_in = 1'b0;
                  zone_in   = uepb_pkg::ZONE_OFF;
                  emit      = 1'b1;
               end else begin
                  den_in    = den_val;
                  div_start = 1'b1;
                  div_num   = uepb_pkg::PERIOD_NUM_M1 + NW'(den_val);
                  div_den   = den_val;
                  mstep_in  = 2'd0;
                  job_in    = uepb_pkg::K_UPDATE;
                  state_in  = ST_WAIT;
               end
            end
            default: begin
               emit = 1'b1;
            end
         endcase
      end

      if (state_ff == ST_WAIT) begin
         prod_in = PW'(mul_a) * PW'(den_ff);
         if (mstep_ff != 2'd3) begin
            mstep_in = mstep_ff + 2'd1;
         end
         case (mstep_ff)
            2'd1:    gt_in = num_ext > prod_ff;
            2'd2:    le_in = num_ext <= prod_ff;
            2'd3:    ge_in = num_ext >= prod_ff;
            default: begin
            end
         endcase
         if (job_ff == uepb_pkg::K_FALL) begin
            dist_in  = dist_prod[XW-1:XW-uepb_pkg::DIST_W];
            emit     = 1'b1;
            state_in = ST_IDLE;
         end else if (div_done) begin
            half_in = (div_quot > NW'(uepb_pkg::PERIOD_MAX)) ?
                      uepb_pkg::PERIOD_MAX : div_quot[uepb_pkg::PERIOD_W-1:0];
            if (le_ff && gt_ff) begin
               toggle_in = 1'b0;
               beeper_in = 1'b1;
               zone_in   = uepb_pkg::ZONE_SOLID;
            end else if (ge_ff || le_ff) begin
               toggle_in = 1'b0;
               beeper_in = 1'b0;
               zone_in   = uepb_pkg::ZONE_OFF;
            end else begin
               toggle_in = 1'b1;
               zone_in   = uepb_pkg::ZONE_BEEP;
            end
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.beeper_on          = beeper_in;
         rsp_in.beep_active        = toggle_in;
         rsp_in.zone               = zone_in;
         rsp_in.echo_width_us      = width_in;
         rsp_in.distance_tenths_cm = dist_in;
         rsp_in.period_ms          = half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         start_ff     <= '0;
         width_ff     <= '0;
         dist_ff      <= '0;
         tick_ff      <= '0;
         half_ff      <= '0;
         toggle_ff    <= 1'b1;
         beeper_ff    <= 1'b1;
         zone_ff      <= uepb_pkg::ZONE_BEEP;
         mstep_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         start_ff     <= start_in;
         width_ff     <= width_in;
         dist_ff      <= dist_in;
         tick_ff      <= tick_in;
         half_ff      <= half_in;
         toggle_ff    <= toggle_in;
         beeper_ff    <= beeper_in;
         zone_ff      <= zone_in;
         mstep_ff     <= mstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      gt_ff   <= gt_in;
      le_ff   <= le_in;
      ge_ff   <= ge_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

// ----- rtl/core/ultrasonic_echo_proximity_beeper.sv -----
// Top level of the ultrasonic echo proximity beeper.
// Depends on uepb_pkg, uepb_front, uepb_div and uepb_back.
//
// Usage:
//   req_* carries requests: tuser selects echo level change, millisecond tick or
//   measurement update; tdata holds the echo level and the microsecond timestamp.
//   rsp_* returns one response per request with the beeper state after it.
//   csr_* writes the no-obstacle, near and far period thresholds; index 3 is ignored.
// Flow:
//   A two-entry queue sits between the request side and the execution side.
//   Rise, tick, unused and unpaired falling-edge requests go from the queue slot
//   to the response register; a falling echo edge that ends a pulse also passes the
//   wait state, its distance taken by a constant multiply. A measurement update waits
//   there for the 20-step period divider. No new request executes while in the wait
//   state; otherwise the rate is one request per cycle while rsp is not stalled.
//   A measurement update with a non-positive denominator skips the divider and wait state.
// Reset empties the queue and drops rsp_tvalid; thresholds return to 33, 40, 800.
// A stalled rsp holds its data; execution waits and the queue fills, then req_tready drops.
module ultrasonic_echo_proximity_beeper (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [1:0]                            req_tuser,  // operation
   input  logic [uepb_pkg::REQ_TDATA_W-1:0]      req_tdata,  // echo_level, timestamp_us
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // beeper_on, beep_active, zone, echo_width_us, distance_tenths_cm, period_ms
   output logic [uepb_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [uepb_pkg::CFG_W-1:0]            csr_wdata
);

   logic                               q_valid;
   uepb_pkg::item_type                 q_item;
   logic                               q_pop;
   logic                               div_start;
   logic [uepb_pkg::DIV_NUM_W-1:0]     div_num;
   logic [uepb_pkg::DIV_DEN_W-1:0]     div_den;
   logic                               div_done;
   logic [uepb_pkg::DIV_NUM_W-1:0]     div_quot;
   uepb_pkg::rsp_type                  rsp;

   uepb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   uepb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   uepb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .div_start  (div_start),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_done   (div_done),
      .div_quot   (div_quot),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {{(uepb_pkg::RSP_TDATA_W - $bits(uepb_pkg::rsp_type)){1'b0}}, rsp};

endmodule
